FILE: hw/rtl/wlqs_pkg.sv
// shared widths, register indexes, sideband types and helpers for the wide line quad setup
`default_nettype none

package wlqs_pkg;

    localparam int POS_W      = 24;
    localparam int WID_W      = 16;
    localparam int TEX_W      = 32;
    localparam int EXT_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SQ_W   = 50;
    localparam int RAD_W  = 58;
    localparam int LEN_W  = 29;

    localparam int NQ_W      = 17;
    localparam int NRM_NUM_W = 45;
    localparam int TUQ_W     = 41;
    localparam int TUN_W     = 41;
    localparam int RCQ_W     = 15;
    localparam int RCN_W     = 25;
    localparam int RCD_W     = 17;
    localparam int DIV_LAT   = 41;

    localparam int NRM_W  = 18;
    localparam int HALF_W = 17;
    localparam int PROD_W = 36;
    localparam int OFS_W  = 19;
    localparam int SUM_W  = 26;
    localparam int TUS_W  = 43;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_REPEAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_SCROLL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AA_ENABLE   = 3'd5;

    localparam logic [WID_W-1:0] TEX_REPEAT_RESET = 16'd256;
    localparam logic [RCD_W-1:0] AA_WIDTH_PAD     = 17'd1024;
    localparam logic [RCN_W-1:0] RECIP_ONE        = 25'h1000000;
    localparam logic signed [TEX_W-1:0] TEX_ONE   = 32'sh00010000;

    typedef struct packed {
        logic                    valid;
        logic signed [EXT_W-1:0] px0;
        logic signed [EXT_W-1:0] py0;
        logic signed [EXT_W-1:0] px1;
        logic signed [EXT_W-1:0] py1;
        logic        [WID_W-1:0] w0;
        logic        [WID_W-1:0] w1;
        logic signed [EXT_W-1:0] dx;
        logic signed [EXT_W-1:0] dy;
    } seg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [EXT_W-1:0] px0;
        logic signed [EXT_W-1:0] py0;
        logic signed [EXT_W-1:0] px1;
        logic signed [EXT_W-1:0] py1;
    } ends_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 26'sd8388607)
            r = 24'sh7fffff;
        else if (v < -26'sd8388608)
            r = 24'sh800000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [TUS_W-1:0] v);
        logic signed [TEX_W-1:0] r;
        if (v > 43'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -43'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[TEX_W-1:0];
        return r;
    endfunction

    // divide by 2^17, nearest, ties away from zero
    function automatic logic signed [OFS_W-1:0] round_ofs(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        logic signed [OFS_W-1:0] r;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        q   = (mag + PROD_W'(65536)) >> 17;
        r   = p[PROD_W-1] ? -signed'(q[OFS_W-1:0]) : signed'(q[OFS_W-1:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wlqs_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module wlqs_sqrt #(
    parameter int RAD_W = 58,
    parameter int TAG_W = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [RAD_W-1:0]   rad,
    input  wire logic [TAG_W-1:0]   tag_in,
    output logic [RAD_W/2-1:0]      root,
    output logic [TAG_W-1:0]        tag_out
);

    localparam int RB = RAD_W / 2;
    localparam int RM = RB + 3;

    logic [RAD_W-1:0] rad_reg  [RB];
    logic [RM-1:0]    rem_reg  [RB];
    logic [RB-1:0]    root_reg [RB];
    logic [TAG_W-1:0] tag_reg  [RB];

    for (genvar j = 0; j < RB; j++)
    begin : g_stage
        logic [RAD_W-1:0] rad_prev;
        logic [RM-1:0]    rem_prev;
        logic [RB-1:0]    root_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [RM-1:0]    cur;
        logic [RM-1:0]    trial;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rad_prev  = rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign tag_prev  = tag_in;
        end
        else
        begin : g_next
            assign rad_prev  = rad_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign tag_prev  = tag_reg[j-1];
        end

        // bring down the next two radicand bits, try (root << 2) | 1
        assign cur   = {rem_prev[RM-3:0], rad_prev[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_prev, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[j] <= '0;
            else if (en)
                tag_reg[j] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j]  <= rad_prev << 2;
                rem_reg[j]  <= ge ? cur - trial : cur;
                root_reg[j] <= {root_prev[RB-2:0], ge};
            end
        end
    end

    assign root    = root_reg[RB-1];
    assign tag_out = tag_reg[RB-1];

endmodule

`default_nettype wire

FILE: hw/rtl/wlqs_div.sv
// pipelined restoring divider, one quotient bit per stage, optional delay padding
`default_nettype none

module wlqs_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 29,
    parameter int QUO_W = 17,
    parameter int PAD   = 0,
    parameter int TAG_W = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic [QUO_W-1:0]      quo,
    output logic [TAG_W-1:0]      tag_out
);

    localparam int CW = DEN_W + QUO_W;

    logic [CW-1:0]    rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int B = QUO_W - 1 - i;
        logic [CW-1:0]    rem_prev;
        logic [CW-1:0]    dsh;
        logic [DEN_W-1:0] den_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [TAG_W-1:0] tag_prev;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_prev = CW'(num);
            assign den_prev = den;
            assign quo_prev = '0;
            assign tag_prev = tag_in;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign quo_prev = quo_reg[i-1];
            assign tag_prev = tag_reg[i-1];
        end

        assign dsh = CW'(den_prev) << B;
        assign ge  = rem_prev >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[i] <= '0;
            else if (en)
                tag_reg[i] <= tag_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? rem_prev - dsh : rem_prev;
                den_reg[i] <= den_prev;
                quo_reg[i] <= {quo_prev[QUO_W-2:0], ge};
            end
        end
    end

    if (PAD > 0)
    begin : g_pad
        logic [QUO_W-1:0] pq_reg [PAD];
        logic [TAG_W-1:0] pt_reg [PAD];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int p = 0; p < PAD; p++)
                    pt_reg[p] <= '0;
            end
            else if (en)
            begin
                pt_reg[0] <= tag_reg[QUO_W-1];
                for (int p = 1; p < PAD; p++)
                    pt_reg[p] <= pt_reg[p-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pq_reg[0] <= quo_reg[QUO_W-1];
                for (int p = 1; p < PAD; p++)
                    pq_reg[p] <= pq_reg[p-1];
            end
        end

        assign quo     = pq_reg[PAD-1];
        assign tag_out = pt_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign quo     = quo_reg[QUO_W-1];
        assign tag_out = tag_reg[QUO_W-1];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wide_line_quad_setup.sv
// wide line quad setup: one segment in, four quad corners out v0..v3
// a segment goes through stages A-C, the sqrt, the dividers, stages E-G and the output buffer
// the buffer loads a segment when empty or as its last corner leaves the one output port;
//   the sqrt (29 stages) and divider (41 stages) take a segment every cycle unless frozen
// a segment in G that the buffer cannot load freezes the pipeline; bubbles travel with it
// reset: async active low, clears valid bits and config (repeat length resets to 1.0)
`default_nettype none

module wide_line_quad_setup (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [wlqs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [wlqs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [wlqs_pkg::POS_W-1:0]      start_x,
    input  wire logic signed [wlqs_pkg::POS_W-1:0]      start_y,
    input  wire logic signed [wlqs_pkg::POS_W-1:0]      end_x,
    input  wire logic signed [wlqs_pkg::POS_W-1:0]      end_y,
    input  wire logic [wlqs_pkg::WID_W-1:0]             start_width,
    input  wire logic [wlqs_pkg::WID_W-1:0]             end_width,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [wlqs_pkg::POS_W-1:0]           vertex_x,
    output logic signed [wlqs_pkg::POS_W-1:0]           vertex_y,
    output logic signed [wlqs_pkg::TEX_W-1:0]           tex_u,
    output logic                                        tex_v_side,
    output logic signed [wlqs_pkg::TEX_W-1:0]           aux_u,
    output logic [wlqs_pkg::WID_W-1:0]                  aux_v,
    output logic                                        at_end,
    output logic                                        last_vertex
);

    localparam int EXT_W  = wlqs_pkg::EXT_W;
    localparam int POS_W  = wlqs_pkg::POS_W;
    localparam int WID_W  = wlqs_pkg::WID_W;
    localparam int TEX_W  = wlqs_pkg::TEX_W;
    localparam int LEN_W  = wlqs_pkg::LEN_W;
    localparam int NRM_W  = wlqs_pkg::NRM_W;
    localparam int HALF_W = wlqs_pkg::HALF_W;
    localparam int PROD_W = wlqs_pkg::PROD_W;
    localparam int OFS_W  = wlqs_pkg::OFS_W;
    localparam int SUM_W  = wlqs_pkg::SUM_W;
    localparam int TUS_W  = wlqs_pkg::TUS_W;
    localparam int SEG_W  = $bits(wlqs_pkg::seg_t);
    localparam int ENDS_W = $bits(wlqs_pkg::ends_t);

    // ---------------- configuration ----------------
    logic signed [POS_W-1:0] offset_x_reg;
    logic signed [POS_W-1:0] offset_y_reg;
    logic [WID_W-1:0]        tex_repeat_reg;
    logic signed [TEX_W-1:0] tex_base_reg;
    logic signed [TEX_W-1:0] tex_scroll_reg;
    logic                    aa_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            tex_repeat_reg <= wlqs_pkg::TEX_REPEAT_RESET;
            tex_base_reg   <= '0;
            tex_scroll_reg <= '0;
            aa_reg         <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wlqs_pkg::REG_OFFSET_X:   offset_x_reg   <= cfg_data[POS_W-1:0];
                wlqs_pkg::REG_OFFSET_Y:   offset_y_reg   <= cfg_data[POS_W-1:0];
                wlqs_pkg::REG_TEX_REPEAT: tex_repeat_reg <= cfg_data[WID_W-1:0];
                wlqs_pkg::REG_TEX_BASE:   tex_base_reg   <= cfg_data[TEX_W-1:0];
                wlqs_pkg::REG_TEX_SCROLL: tex_scroll_reg <= cfg_data[TEX_W-1:0];
                wlqs_pkg::REG_AA_ENABLE:  aa_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic       adv;
    logic       load_ok;
    logic       g_valid_reg;
    logic       out_valid_reg;
    logic [1:0] cnt_reg;

    assign load_ok  = !out_valid_reg || (!out_stall && cnt_reg == 2'd3);
    assign adv      = !g_valid_reg || load_ok;
    assign in_stall = !adv;

    // ---------------- stage A: endpoints and deltas ----------------
    wlqs_pkg::seg_t a_next;
    wlqs_pkg::seg_t a_reg;

    always_comb
    begin
        a_next.valid = in_valid;
        a_next.px0   = EXT_W'(start_x) + EXT_W'(offset_x_reg);
        a_next.py0   = EXT_W'(start_y) + EXT_W'(offset_y_reg);
        a_next.px1   = EXT_W'(end_x) + EXT_W'(offset_x_reg);
        a_next.py1   = EXT_W'(end_y) + EXT_W'(offset_y_reg);
        a_next.w0    = start_width;
        a_next.w1    = end_width;
        a_next.dx    = EXT_W'(end_x) - EXT_W'(start_x);
        a_next.dy    = EXT_W'(end_y) - EXT_W'(start_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_reg <= '0;
        else if (adv)
            a_reg <= a_next;
    end

    // ---------------- stage B: squares ----------------
    wlqs_pkg::seg_t                 b_reg;
    logic [wlqs_pkg::SQ_W-1:0]      b_sqx_reg;
    logic [wlqs_pkg::SQ_W-1:0]      b_sqy_reg;
    logic signed [2*EXT_W-1:0]      sqx_full;
    logic signed [2*EXT_W-1:0]      sqy_full;

    assign sqx_full = a_reg.dx * a_reg.dx;
    assign sqy_full = a_reg.dy * a_reg.dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_reg <= '0;
        else if (adv)
            b_reg <= a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sqx_reg <= sqx_full[wlqs_pkg::SQ_W-1:0];
            b_sqy_reg <= sqy_full[wlqs_pkg::SQ_W-1:0];
        end
    end

    // ---------------- stage C: radicand ----------------
    wlqs_pkg::seg_t                 c_reg;
    logic [wlqs_pkg::RAD_W-1:0]     c_rad_reg;
    logic [wlqs_pkg::SQ_W:0]        sq_sum;

    assign sq_sum = (wlqs_pkg::SQ_W+1)'(b_sqx_reg) + (wlqs_pkg::SQ_W+1)'(b_sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (adv)
            c_reg <= b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c_rad_reg <= {sq_sum[wlqs_pkg::SQ_W-1:0], 8'd0};
    end

    // ---------------- length ----------------
    logic [LEN_W-1:0] len;
    logic [SEG_W-1:0] sq_tag;
    wlqs_pkg::seg_t   sq_seg;

    wlqs_sqrt #(
        .RAD_W (wlqs_pkg::RAD_W),
        .TAG_W (SEG_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .rad     (c_rad_reg),
        .tag_in  (c_reg),
        .root    (len),
        .tag_out (sq_tag)
    );

    assign sq_seg = wlqs_pkg::seg_t'(sq_tag);

    // ---------------- dividers ----------------
    logic [EXT_W-1:0]               dx_mag;
    logic [EXT_W-1:0]               dy_mag;
    logic [wlqs_pkg::NRM_NUM_W-1:0] nx_num;
    logic [wlqs_pkg::NRM_NUM_W-1:0] ny_num;
    logic [wlqs_pkg::RCD_W-1:0]     d0;
    logic [wlqs_pkg::RCD_W-1:0]     d1;
    logic [wlqs_pkg::RCN_W-1:0]     rc0_num;
    logic [wlqs_pkg::RCN_W-1:0]     rc1_num;
    logic [WID_W-1:0]               rep;
    wlqs_pkg::ends_t                ends_in;

    assign dx_mag  = sq_seg.dx[EXT_W-1] ? EXT_W'(-sq_seg.dx) : EXT_W'(sq_seg.dx);
    assign dy_mag  = sq_seg.dy[EXT_W-1] ? EXT_W'(-sq_seg.dy) : EXT_W'(sq_seg.dy);
    assign nx_num  = wlqs_pkg::NRM_NUM_W'({dy_mag, 20'd0}) + wlqs_pkg::NRM_NUM_W'(len[LEN_W-1:1]);
    assign ny_num  = wlqs_pkg::NRM_NUM_W'({dx_mag, 20'd0}) + wlqs_pkg::NRM_NUM_W'(len[LEN_W-1:1]);
    assign d0      = wlqs_pkg::RCD_W'(sq_seg.w0) + wlqs_pkg::AA_WIDTH_PAD;
    assign d1      = wlqs_pkg::RCD_W'(sq_seg.w1) + wlqs_pkg::AA_WIDTH_PAD;
    assign rc0_num = wlqs_pkg::RECIP_ONE + wlqs_pkg::RCN_W'(d0[wlqs_pkg::RCD_W-1:1]);
    assign rc1_num = wlqs_pkg::RECIP_ONE + wlqs_pkg::RCN_W'(d1[wlqs_pkg::RCD_W-1:1]);
    // a zero repeat length counts as one
    assign rep     = (tex_repeat_reg == '0) ? WID_W'(1) : tex_repeat_reg;

    always_comb
    begin
        ends_in.valid = sq_seg.valid;
        ends_in.px0   = sq_seg.px0;
        ends_in.py0   = sq_seg.py0;
        ends_in.px1   = sq_seg.px1;
        ends_in.py1   = sq_seg.py1;
    end

    logic [wlqs_pkg::NQ_W-1:0]  nx_q;
    logic [wlqs_pkg::NQ_W-1:0]  ny_q;
    logic [wlqs_pkg::TUQ_W-1:0] tu_q;
    logic [wlqs_pkg::RCQ_W-1:0] rc0_q;
    logic [wlqs_pkg::RCQ_W-1:0] rc1_q;
    logic [1:0]                 nx_tag;
    logic                       ny_tag;
    logic [WID_W-1:0]           w0_d;
    logic [WID_W-1:0]           w1_d;
    logic [ENDS_W-1:0]          ends_tag;
    wlqs_pkg::ends_t            ends_d;

    wlqs_div #(
        .NUM_W (wlqs_pkg::NRM_NUM_W),
        .DEN_W (LEN_W),
        .QUO_W (wlqs_pkg::NQ_W),
        .PAD   (wlqs_pkg::DIV_LAT - wlqs_pkg::NQ_W),
        .TAG_W (2)
    ) u_div_nx (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     (nx_num),
        .den     (len),
        .tag_in  ({sq_seg.dy[EXT_W-1], len == '0}),
        .quo     (nx_q),
        .tag_out (nx_tag)
    );

    // ny takes the sign of -dx
    wlqs_div #(
        .NUM_W (wlqs_pkg::NRM_NUM_W),
        .DEN_W (LEN_W),
        .QUO_W (wlqs_pkg::NQ_W),
        .PAD   (wlqs_pkg::DIV_LAT - wlqs_pkg::NQ_W),
        .TAG_W (1)
    ) u_div_ny (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     (ny_num),
        .den     (len),
        .tag_in  (!sq_seg.dx[EXT_W-1] && sq_seg.dx != '0),
        .quo     (ny_q),
        .tag_out (ny_tag)
    );

    wlqs_div #(
        .NUM_W (wlqs_pkg::TUN_W),
        .DEN_W (WID_W),
        .QUO_W (wlqs_pkg::TUQ_W),
        .PAD   (wlqs_pkg::DIV_LAT - wlqs_pkg::TUQ_W),
        .TAG_W (ENDS_W)
    ) u_div_tu (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     ({len, 12'd0}),
        .den     (rep),
        .tag_in  (ends_in),
        .quo     (tu_q),
        .tag_out (ends_tag)
    );

    wlqs_div #(
        .NUM_W (wlqs_pkg::RCN_W),
        .DEN_W (wlqs_pkg::RCD_W),
        .QUO_W (wlqs_pkg::RCQ_W),
        .PAD   (wlqs_pkg::DIV_LAT - wlqs_pkg::RCQ_W),
        .TAG_W (WID_W)
    ) u_div_rc0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     (rc0_num),
        .den     (d0),
        .tag_in  (sq_seg.w0),
        .quo     (rc0_q),
        .tag_out (w0_d)
    );

    wlqs_div #(
        .NUM_W (wlqs_pkg::RCN_W),
        .DEN_W (wlqs_pkg::RCD_W),
        .QUO_W (wlqs_pkg::RCQ_W),
        .PAD   (wlqs_pkg::DIV_LAT - wlqs_pkg::RCQ_W),
        .TAG_W (WID_W)
    ) u_div_rc1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .num     (rc1_num),
        .den     (d1),
        .tag_in  (sq_seg.w1),
        .quo     (rc1_q),
        .tag_out (w1_d)
    );

    assign ends_d = wlqs_pkg::ends_t'(ends_tag);

    // ---------------- stage E: normal, texture u, half widths ----------------
    logic                       e_valid_reg;
    logic signed [EXT_W-1:0]    e_px_reg [2];
    logic signed [EXT_W-1:0]    e_py_reg [2];
    logic signed [NRM_W-1:0]    e_nx_reg;
    logic signed [NRM_W-1:0]    e_ny_reg;
    logic signed [TEX_W-1:0]    e_tu_reg [2];
    logic [HALF_W-1:0]          e_h_reg  [2];
    logic [WID_W-1:0]           e_w_reg  [2];
    logic [wlqs_pkg::RCQ_W-1:0] e_r_reg  [2];

    logic signed [NRM_W-1:0]    nx_s;
    logic signed [NRM_W-1:0]    ny_s;
    logic signed [NRM_W-1:0]    nx_v;
    logic signed [NRM_W-1:0]    ny_v;
    logic signed [TUS_W-1:0]    tu0_sum;
    logic signed [TUS_W-1:0]    tu1_sum;
    logic [HALF_W-1:0]          h_pad;

    assign nx_s    = signed'(NRM_W'(nx_q));
    assign ny_s    = signed'(NRM_W'(ny_q));
    // zero-length segment gives a zero normal
    assign nx_v    = nx_tag[0] ? '0 : (nx_tag[1] ? -nx_s : nx_s);
    assign ny_v    = nx_tag[0] ? '0 : (ny_tag ? -ny_s : ny_s);
    assign tu0_sum = TUS_W'(tex_base_reg) - TUS_W'(tex_scroll_reg);
    assign tu1_sum = tu0_sum + signed'(TUS_W'(tu_q));
    assign h_pad   = aa_reg ? wlqs_pkg::AA_WIDTH_PAD : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (adv)
            e_valid_reg <= ends_d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_px_reg[0] <= ends_d.px0;
            e_py_reg[0] <= ends_d.py0;
            e_px_reg[1] <= ends_d.px1;
            e_py_reg[1] <= ends_d.py1;
            e_nx_reg    <= nx_v;
            e_ny_reg    <= ny_v;
            e_tu_reg[0] <= wlqs_pkg::sat_tex(tu0_sum);
            e_tu_reg[1] <= wlqs_pkg::sat_tex(tu1_sum);
            e_h_reg[0]  <= HALF_W'(w0_d) + h_pad;
            e_h_reg[1]  <= HALF_W'(w1_d) + h_pad;
            e_w_reg[0]  <= w0_d;
            e_w_reg[1]  <= w1_d;
            e_r_reg[0]  <= rc0_q;
            e_r_reg[1]  <= rc1_q;
        end
    end

    // ---------------- stage F: normal times half width ----------------
    logic                       f_valid_reg;
    logic signed [EXT_W-1:0]    f_px_reg [2];
    logic signed [EXT_W-1:0]    f_py_reg [2];
    logic signed [PROD_W-1:0]   f_prx_reg [2];
    logic signed [PROD_W-1:0]   f_pry_reg [2];
    logic signed [TEX_W-1:0]    f_tu_reg [2];
    logic [WID_W-1:0]           f_w_reg  [2];
    logic [wlqs_pkg::RCQ_W-1:0] f_r_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < 2; e++)
            begin
                f_px_reg[e]  <= e_px_reg[e];
                f_py_reg[e]  <= e_py_reg[e];
                f_prx_reg[e] <= e_nx_reg * signed'(NRM_W'(e_h_reg[e]));
                f_pry_reg[e] <= e_ny_reg * signed'(NRM_W'(e_h_reg[e]));
                f_tu_reg[e]  <= e_tu_reg[e];
                f_w_reg[e]   <= e_w_reg[e];
                f_r_reg[e]   <= e_r_reg[e];
            end
        end
    end

    // ---------------- stage G: corner offsets ----------------
    logic signed [EXT_W-1:0]    g_px_reg [2];
    logic signed [EXT_W-1:0]    g_py_reg [2];
    logic signed [OFS_W-1:0]    g_ox_reg [2];
    logic signed [OFS_W-1:0]    g_oy_reg [2];
    logic signed [TEX_W-1:0]    g_tu_reg [2];
    logic [WID_W-1:0]           g_w_reg  [2];
    logic [wlqs_pkg::RCQ_W-1:0] g_r_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (adv)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < 2; e++)
            begin
                g_px_reg[e] <= f_px_reg[e];
                g_py_reg[e] <= f_py_reg[e];
                g_ox_reg[e] <= wlqs_pkg::round_ofs(f_prx_reg[e]);
                g_oy_reg[e] <= wlqs_pkg::round_ofs(f_pry_reg[e]);
                g_tu_reg[e] <= f_tu_reg[e];
                g_w_reg[e]  <= f_w_reg[e];
                g_r_reg[e]  <= f_r_reg[e];
            end
        end
    end

    // ---------------- output buffer: four corners of one segment ----------------
    logic signed [POS_W-1:0] o_vx_reg [4];
    logic signed [POS_W-1:0] o_vy_reg [4];
    logic signed [TEX_W-1:0] o_au_reg [4];
    logic [WID_W-1:0]        o_av_reg [4];
    logic signed [TEX_W-1:0] o_tu_reg [2];
    logic signed [POS_W-1:0] vx_next  [4];
    logic signed [POS_W-1:0] vy_next  [4];
    logic signed [TEX_W-1:0] au_next  [4];
    logic [WID_W-1:0]        av_next  [4];
    logic                    load;

    assign load = g_valid_reg && load_ok;

    always_comb
    begin
        logic                    side;
        logic                    e;
        logic signed [SUM_W-1:0] bx;
        logic signed [SUM_W-1:0] by;
        logic signed [SUM_W-1:0] ox;
        logic signed [SUM_W-1:0] oy;
        logic signed [TEX_W-1:0] r;
        for (int k = 0; k < 4; k++)
        begin
            side = (k == 1) || (k == 2);
            e    = (k >= 2);
            bx   = SUM_W'(g_px_reg[e]);
            by   = SUM_W'(g_py_reg[e]);
            ox   = SUM_W'(g_ox_reg[e]);
            oy   = SUM_W'(g_oy_reg[e]);
            r    = signed'(TEX_W'(g_r_reg[e]));
            vx_next[k] = wlqs_pkg::sat_pos(side ? bx + ox : bx - ox);
            vy_next[k] = wlqs_pkg::sat_pos(side ? by + oy : by - oy);
            if (aa_reg)
            begin
                au_next[k] = side ? wlqs_pkg::TEX_ONE + r : -r;
                av_next[k] = g_w_reg[e];
            end
            else
            begin
                au_next[k] = g_tu_reg[e];
                av_next[k] = side ? WID_W'(256) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            if (cnt_reg == 2'd3)
                out_valid_reg <= 1'b0;
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                o_vx_reg[k] <= vx_next[k];
                o_vy_reg[k] <= vy_next[k];
                o_au_reg[k] <= au_next[k];
                o_av_reg[k] <= av_next[k];
            end
            o_tu_reg[0] <= g_tu_reg[0];
            o_tu_reg[1] <= g_tu_reg[1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex_x    = o_vx_reg[cnt_reg];
    assign vertex_y    = o_vy_reg[cnt_reg];
    assign tex_u       = o_tu_reg[cnt_reg[1]];
    assign tex_v_side  = cnt_reg[0] ^ cnt_reg[1];
    assign aux_u       = o_au_reg[cnt_reg];
    assign aux_v       = o_av_reg[cnt_reg];
    assign at_end      = cnt_reg[1];
    assign last_vertex = cnt_reg == 2'd3;

endmodule

`default_nettype wire

FILE: sim/tb_wide_line_quad_setup.sv
// self-checking testbench for the wide line quad setup block
`timescale 1ns / 1ps

module tb_wide_line_quad_setup;

    localparam int POS_W      = wlqs_pkg::POS_W;
    localparam int WID_W      = wlqs_pkg::WID_W;
    localparam int TEX_W      = wlqs_pkg::TEX_W;
    localparam int CFG_IDX_W  = wlqs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wlqs_pkg::CFG_DATA_W;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] ex;
        logic signed [POS_W-1:0] ey;
        logic [WID_W-1:0]        w0;
        logic [WID_W-1:0]        w1;
    } segment_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] vy;
        logic signed [TEX_W-1:0] tu;
        logic                    side;
        logic signed [TEX_W-1:0] au;
        logic [WID_W-1:0]        av;
        logic                    at_end;
        logic                    last;
    } corner_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [POS_W-1:0] start_x, start_y, end_x, end_y;
    logic [WID_W-1:0] start_width, end_width;
    logic out_valid;
    logic out_stall;
    logic signed [POS_W-1:0] vertex_x, vertex_y;
    logic signed [TEX_W-1:0] tex_u, aux_u;
    logic tex_v_side;
    logic [WID_W-1:0] aux_v;
    logic at_end, last_vertex;

    wide_line_quad_setup u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .start_width(start_width), .end_width(end_width),
        .out_valid(out_valid), .out_stall(out_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .tex_u(tex_u),
        .tex_v_side(tex_v_side), .aux_u(aux_u), .aux_v(aux_v),
        .at_end(at_end), .last_vertex(last_vertex)
    );

    // shadow copy of the registers
    longint off_x, off_y, tex_base, tex_scroll;
    longint unsigned repeat_len;
    bit aa_on;

    corner_t expected_corners[$];
    int errors;
    int mismatches;
    int idle_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_half_away(longint num, longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    task automatic predict_quad(segment_t s);
        longint px[2], py[2], half[2], tu[2], rcp[2];
        longint unsigned wd[2];
        longint dx, dy, nx, ny, ox, oy, vx, vy, au;
        longint unsigned len, rep;
        corner_t c;
        int e;
        bit sd;
        px[0] = longint'(s.sx) + off_x;
        py[0] = longint'(s.sy) + off_y;
        px[1] = longint'(s.ex) + off_x;
        py[1] = longint'(s.ey) + off_y;
        wd[0] = s.w0;
        wd[1] = s.w1;
        dx = longint'(s.ex) - longint'(s.sy) * 0 - longint'(s.sx);
        dy = longint'(s.ey) - longint'(s.sy);
        len = int_sqrt((longint'(dx * dx) + longint'(dy * dy)) << 8);
        nx = 0;
        ny = 0;
        if (len != 0)
        begin
            nx = round_half_away(dy * (longint'(1) << 20), len);
            ny = round_half_away(-dx * (longint'(1) << 20), len);
        end
        rep = repeat_len != 0 ? repeat_len : 1;
        tu[0] = clamp(tex_base - tex_scroll, 32);
        tu[1] = clamp(tex_base + longint'((len << 12) / rep) - tex_scroll, 32);
        for (int k = 0; k < 2; k++)
        begin
            half[k] = longint'(wd[k]) + (aa_on ? 1024 : 0);
            rcp[k] = ((longint'(1) << 24) + (wd[k] + 1024) / 2) / (wd[k] + 1024);
        end
        for (int k = 0; k < 4; k++)
        begin
            e = int'(k >= 2);
            sd = (k == 1 || k == 2);
            ox = round_half_away(nx * half[e], longint'(1) << 17);
            oy = round_half_away(ny * half[e], longint'(1) << 17);
            vx = sd ? px[e] + ox : px[e] - ox;
            vy = sd ? py[e] + oy : py[e] - oy;
            c.vx = POS_W'(clamp(vx, 24));
            c.vy = POS_W'(clamp(vy, 24));
            c.tu = TEX_W'(tu[e]);
            c.side = sd;
            if (aa_on)
            begin
                au = sd ? 65536 + rcp[e] : -rcp[e];
                c.au = TEX_W'(clamp(au, 32));
                c.av = WID_W'(wd[e]);
            end
            else
            begin
                c.au = TEX_W'(tu[e]);
                c.av = sd ? 16'd256 : 16'd0;
            end
            c.at_end = 1'(e);
            c.last = (k == 3);
            expected_corners.push_back(c);
        end
    endtask

    // input driver; valid stays high into the next item unless an idle cycle comes
    task automatic send_segment(segment_t s);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= s.sx;
        start_y <= s.sy;
        end_x <= s.ex;
        end_y <= s.ey;
        start_width <= s.w0;
        end_width <= s.w1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_quad(s);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_corners.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            wlqs_pkg::REG_OFFSET_X:   off_x = longint'($signed(val[POS_W-1:0]));
            wlqs_pkg::REG_OFFSET_Y:   off_y = longint'($signed(val[POS_W-1:0]));
            wlqs_pkg::REG_TEX_REPEAT: repeat_len = val[WID_W-1:0];
            wlqs_pkg::REG_TEX_BASE:   tex_base = longint'($signed(val));
            wlqs_pkg::REG_TEX_SCROLL: tex_scroll = longint'($signed(val));
            wlqs_pkg::REG_AA_ENABLE:  aa_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] rep,
                           logic [31:0] base, logic [31:0] scr, logic [31:0] aa);
        wait_drained();
        write_reg(wlqs_pkg::REG_OFFSET_X, ox);
        write_reg(wlqs_pkg::REG_OFFSET_Y, oy);
        write_reg(wlqs_pkg::REG_TEX_REPEAT, rep);
        write_reg(wlqs_pkg::REG_TEX_BASE, base);
        write_reg(wlqs_pkg::REG_TEX_SCROLL, scr);
        write_reg(wlqs_pkg::REG_AA_ENABLE, aa);
        cfg_valid <= 1'b0;
    endtask

    function automatic segment_t random_segment();
        segment_t s;
        s.sx = POS_W'($urandom);
        s.sy = POS_W'($urandom);
        case ($urandom_range(3))
            0: begin s.ex = POS_W'($urandom); s.ey = POS_W'($urandom); end
            1: begin
                s.ex = s.sx + $signed(24'($urandom_range(4095)) - 24'sd2048);
                s.ey = s.sy + $signed(24'($urandom_range(4095)) - 24'sd2048);
            end
            2: begin s.ex = s.sx; s.ey = s.sy + $signed(24'($urandom_range(255))); end
            default: begin s.ex = s.sx; s.ey = s.sy; end
        endcase
        s.w0 = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2047));
        s.w1 = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2047));
        return s;
    endfunction

    task automatic test_directed();
        segment_t s;
        s = '{24'sd0, 24'sd0, 24'sd2560, 24'sd0, 16'd512, 16'd1024};
        send_segment(s);
        s = '{24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'd256, 16'd256};
        send_segment(s);
        s = '{24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 16'hffff, 16'hffff};
        send_segment(s);
        s = '{24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff, 16'd0, 16'hffff};
        send_segment(s);
        s = '{24'sd0, 24'sd0, 24'sd0, -24'sd768, 16'd300, 16'd0};
        send_segment(s);
        s = '{24'sh7fff00, 24'sd0, 24'sh7fff00, 24'sd256, 16'hffff, 16'd0};
        send_segment(s);
        s = '{24'sd3, -24'sd5, -24'sd7, 24'sd11, 16'd1, 16'd3};
        send_segment(s);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_segment(random_segment());
    endtask

    task automatic test_drain_pause();
        test_random(10);
        in_valid <= 1'b0;
        while (expected_corners.size() != 0)
            @(posedge clk);
        test_random(10);
    endtask

    // result checker
    always @(posedge clk)
    begin
        corner_t got;
        corner_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{vertex_x, vertex_y, tex_u, tex_v_side, aux_u, aux_v, at_end, last_vertex};
            if (expected_corners.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected corner %p", got);
            end
            else
            begin
                want = expected_corners.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("corner mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // output stall
    always @(posedge clk)
    begin
        out_stall <= idle_pct > 0 && $urandom_range(99) < idle_pct;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        start_width = '0;
        end_width = '0;
        out_stall = 1'b0;
        errors = 0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_pct = 33;
        off_x = 0;
        off_y = 0;
        repeat_len = wlqs_pkg::TEX_REPEAT_RESET;
        tex_base = 0;
        tex_scroll = 0;
        aa_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(30);
        set_all(32'h7fffff, 32'h800000, 32'd1, 32'h7fffffff, 32'h80000000, 32'd1);
        test_directed();
        test_random(40);
        set_all(32'h1234, 32'hfffe00, 32'd0, 32'h80000000, 32'h7fffffff, 32'd0);
        test_random(40);
        set_all(32'h800000, 32'h7fffff, 32'hffff, 32'h00010000, 32'hffff8000, 32'd1);
        idle_pct = 0;
        test_random(60);
        idle_pct = 33;
        test_drain_pause();
        set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random(60);
        set_all(32'd0, 32'd0, 32'd256, 32'd0, 32'd0, 32'd0);
        test_random(46);
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
